[rtl/v3n_pkg.sv]
// Package for the 3D vector normalizer.
// Holds the default field widths; no dependencies.
package v3n_pkg;

    localparam int COMPONENT_BITS       = 16;
    localparam int LENGTH_FRACTION_BITS = 8;

endpackage

[rtl/v3n_in_if.sv]
// Input channel of the 3D vector normalizer: valid/ready plus one vector.
// Depends on v3n_pkg for default widths.
interface v3n_in_if #(
    parameter int CB = v3n_pkg::COMPONENT_BITS
) ();
    logic                 valid;
    logic                 ready;
    logic signed [CB-1:0] x_in;
    logic signed [CB-1:0] y_in;
    logic signed [CB-1:0] z_in;

    modport source (output valid, output x_in, output y_in, output z_in, input ready);
    modport sink   (input valid, input x_in, input y_in, input z_in, output ready);
endinterface

[rtl/v3n_out_if.sv]
// Output channel of the 3D vector normalizer: unit vector, length, zero flag.
// Depends on v3n_pkg for default widths.
interface v3n_out_if #(
    parameter int CB = v3n_pkg::COMPONENT_BITS,
    parameter int LB = v3n_pkg::LENGTH_FRACTION_BITS
) ();
    logic                 valid;
    logic                 ready;
    logic signed [CB-1:0] unit_x;
    logic signed [CB-1:0] unit_y;
    logic signed [CB-1:0] unit_z;
    logic [CB+LB-1:0]     magnitude;
    logic                 zero_vector;

    modport source (output valid, output unit_x, output unit_y, output unit_z,
                    output magnitude, output zero_vector, input ready);
    modport sink   (input valid, input unit_x, input unit_y, input unit_z,
                    input magnitude, input zero_vector, output ready);
endinterface

[rtl/v3n_sqrt_cell.sv]
// One restoring square-root step: produces one root bit per cell.
// Carries radicand and side data to the next cell; no package use.
module v3n_sqrt_cell #(
    parameter int R      = 24,
    parameter int STEP   = 23,
    parameter int SIDE_W = 52
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              valid_in,
    input  logic [2*R-1:0]    rad_in,
    input  logic [R+1:0]      rem_in,
    input  logic [R-1:0]      root_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              valid_reg,
    output logic [2*R-1:0]    rad_reg,
    output logic [R+1:0]      rem_reg,
    output logic [R-1:0]      root_reg,
    output logic [SIDE_W-1:0] side_reg
);
    logic [R+1:0] rem_shift;
    logic [R+1:0] trial;
    logic         take;
    logic [R+1:0] rem_next;
    logic [R-1:0] root_next;

    always_comb
    begin
        rem_shift = {rem_in[R-1:0], rad_in[2*STEP +: 2]};
        trial     = {root_in, 2'b01};
        take      = (rem_shift >= trial);
        rem_next  = take ? (rem_shift - trial) : rem_shift;
        root_next = {root_in[R-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rad_reg  <= rad_in;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end
endmodule

[rtl/v3n_div_cell.sv]
// One restoring division step for all three components: one quotient bit each.
// Carries the divisor and side data to the next cell; no package use.
module v3n_div_cell #(
    parameter int CB     = 16,
    parameter int R      = 24,
    parameter bit FIRST  = 1'b0,
    parameter int SIDE_W = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 valid_in,
    input  logic [R-1:0]         mag_in,
    input  logic [2:0][R-1:0]    part_in,
    input  logic [2:0][CB-1:0]   quo_in,
    input  logic [SIDE_W-1:0]    side_in,
    output logic                 valid_reg,
    output logic [R-1:0]         mag_reg,
    output logic [2:0][R-1:0]    part_reg,
    output logic [2:0][CB-1:0]   quo_reg,
    output logic [SIDE_W-1:0]    side_reg
);
    logic [2:0][R:0]    trial;
    logic [2:0]         take;
    logic [2:0][R-1:0]  part_next;
    logic [2:0][CB-1:0] quo_next;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            trial[c]     = FIRST ? {1'b0, part_in[c]} : {part_in[c], 1'b0};
            take[c]      = (trial[c] >= {1'b0, mag_in});
            part_next[c] = take[c] ? R'(trial[c] - {1'b0, mag_in}) : R'(trial[c]);
            quo_next[c]  = {quo_in[c][CB-2:0], take[c]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mag_reg  <= mag_in;
            part_reg <= part_next;
            quo_reg  <= quo_next;
            side_reg <= side_in;
        end
    end
endmodule

[rtl/vector3_normalize.sv]
// Top level of the 3D vector normalizer: front end, square-root and divider rows.
// Depends on v3n_pkg, v3n_in_if, v3n_out_if, v3n_sqrt_cell and v3n_div_cell.
//
// Usage:
//   vec_in carries one vector (x_in, y_in, z_in, signed) per item; vec_out
//   returns the unit vector (Q1.(CB-1), saturated), the floored length with
//   LENGTH_FRACTION_BITS fraction bits, and a flag for the all-zero vector.
//   From accept to output valid an item passes three front-end stages for
//   the absolute values, squares and sum, one cell per root bit, one cell
//   per quotient bit, and the output register.
//   Throughput is one item per cycle while vec_out.ready stays high; every
//   cell holds one item in flight.
//   The whole pipeline advances together; when the receiver holds ready low
//   with a result waiting, every stage holds and vec_in.ready drops.
//   Reset clears all valid flags; the block then accepts items at once.
module vector3_normalize #(
    parameter int COMPONENT_BITS       = v3n_pkg::COMPONENT_BITS,
    parameter int LENGTH_FRACTION_BITS = v3n_pkg::LENGTH_FRACTION_BITS
) (
    input logic       clk,
    input logic       rst_n,
    v3n_in_if.sink    vec_in,
    v3n_out_if.source vec_out
);
    localparam int CB      = COMPONENT_BITS;
    localparam int L       = LENGTH_FRACTION_BITS;
    localparam int R       = CB + L;
    localparam int SQ_SIDE = 4 + 3 * CB;
    localparam int DV_SIDE = 4;

    logic advance;
    logic out_valid_reg;

    assign advance      = !out_valid_reg || vec_out.ready;
    assign vec_in.ready = advance;

    // front end
    logic [2:0][CB-1:0]   comp;
    logic [2:0][CB-1:0]   abs_val;
    logic                 v1_reg, v2_reg, v3_reg;
    logic [2:0][CB-1:0]   a1_reg, a2_reg, a3_reg;
    logic [2:0]           n1_reg, n2_reg, n3_reg;
    logic [2:0][2*CB-1:0] sq2_reg;
    logic [2*CB+1:0]      sum_wide;
    logic [2*CB-1:0]      sum3_reg;
    logic                 zero3_reg;

    always_comb
    begin
        comp[0] = vec_in.x_in;
        comp[1] = vec_in.y_in;
        comp[2] = vec_in.z_in;
        for (int c = 0; c < 3; c++)
        begin
            abs_val[c] = comp[c][CB-1] ? (~comp[c] + 1'b1) : comp[c];
        end
        sum_wide = (2*CB+2)'(sq2_reg[0]) + (2*CB+2)'(sq2_reg[1])
                 + (2*CB+2)'(sq2_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= vec_in.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int c = 0; c < 3; c++)
            begin
                a1_reg[c]  <= abs_val[c];
                n1_reg[c]  <= comp[c][CB-1];
                sq2_reg[c] <= (2*CB)'(a1_reg[c]) * (2*CB)'(a1_reg[c]);
            end
            a2_reg    <= a1_reg;
            n2_reg    <= n1_reg;
            a3_reg    <= a2_reg;
            n3_reg    <= n2_reg;
            sum3_reg  <= sum_wide[2*CB-1:0];
            zero3_reg <= (sum_wide == '0);
        end
    end

    // square-root row
    logic [R:0]               sq_valid;
    logic [R:0][2*R-1:0]      sq_rad;
    logic [R:0][R+1:0]        sq_rem;
    logic [R:0][R-1:0]        sq_root;
    logic [R:0][SQ_SIDE-1:0]  sq_side;

    assign sq_valid[0] = v3_reg;
    assign sq_rad[0]   = (2*R)'(sum3_reg) << (2*L);
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_side[0]  = {zero3_reg, n3_reg, a3_reg};

    for (genvar i = 0; i < R; i++)
    begin : g_sqrt
        v3n_sqrt_cell #(
            .R      (R),
            .STEP   (R - 1 - i),
            .SIDE_W (SQ_SIDE)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (sq_valid[i]),
            .rad_in    (sq_rad[i]),
            .rem_in    (sq_rem[i]),
            .root_in   (sq_root[i]),
            .side_in   (sq_side[i]),
            .valid_reg (sq_valid[i+1]),
            .rad_reg   (sq_rad[i+1]),
            .rem_reg   (sq_rem[i+1]),
            .root_reg  (sq_root[i+1]),
            .side_reg  (sq_side[i+1])
        );
    end

    // divider row
    logic [CB:0]                 dv_valid;
    logic [CB:0][R-1:0]          dv_mag;
    logic [CB:0][2:0][R-1:0]     dv_part;
    logic [CB:0][2:0][CB-1:0]    dv_quo;
    logic [CB:0][DV_SIDE-1:0]    dv_side;
    logic [2:0][CB-1:0]          sq_abs;

    assign sq_abs      = sq_side[R][3*CB-1:0];
    assign dv_valid[0] = sq_valid[R];
    assign dv_mag[0]   = sq_root[R];
    assign dv_quo[0]   = '0;
    assign dv_side[0]  = sq_side[R][SQ_SIDE-1:3*CB];

    for (genvar c = 0; c < 3; c++)
    begin : g_part
        assign dv_part[0][c] = R'(sq_abs[c]) << L;
    end

    for (genvar j = 0; j < CB; j++)
    begin : g_div
        v3n_div_cell #(
            .CB     (CB),
            .R      (R),
            .FIRST  (j == 0),
            .SIDE_W (DV_SIDE)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (dv_valid[j]),
            .mag_in    (dv_mag[j]),
            .part_in   (dv_part[j]),
            .quo_in    (dv_quo[j]),
            .side_in   (dv_side[j]),
            .valid_reg (dv_valid[j+1]),
            .mag_reg   (dv_mag[j+1]),
            .part_reg  (dv_part[j+1]),
            .quo_reg   (dv_quo[j+1]),
            .side_reg  (dv_side[j+1])
        );
    end

    // output stage: sign, saturate, zero override
    localparam logic [CB-1:0] POS_MAX = {1'b0, {(CB-1){1'b1}}};

    logic                 zero_fin;
    logic [2:0]           neg_fin;
    logic [2:0][CB-1:0]   unit_next;
    logic [2:0][CB-1:0]   unit_reg;
    logic [R-1:0]         mag_reg;
    logic                 zero_reg;

    always_comb
    begin
        zero_fin = dv_side[CB][3];
        neg_fin  = dv_side[CB][2:0];
        for (int c = 0; c < 3; c++)
        begin
            if (zero_fin)
            begin
                unit_next[c] = '0;
            end
            else if (neg_fin[c])
            begin
                unit_next[c] = ~dv_quo[CB][c] + 1'b1;
            end
            else
            begin
                unit_next[c] = (dv_quo[CB][c] > POS_MAX) ? POS_MAX : dv_quo[CB][c];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= dv_valid[CB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            unit_reg <= unit_next;
            mag_reg  <= zero_fin ? '0 : dv_mag[CB];
            zero_reg <= zero_fin;
        end
    end

    assign vec_out.valid       = out_valid_reg;
    assign vec_out.unit_x      = unit_reg[0];
    assign vec_out.unit_y      = unit_reg[1];
    assign vec_out.unit_z      = unit_reg[2];
    assign vec_out.magnitude   = mag_reg;
    assign vec_out.zero_vector = zero_reg;

    a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && zero_reg |-> mag_reg == '0 && unit_reg == '0)
        else $error("zero vector with nonzero result");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !zero_reg |-> mag_reg != '0)
        else $error("nonzero vector with zero length");

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(sq_valid) && $stable(dv_valid))
        else $error("pipeline moved while stalled");

    a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid[R] |-> sq_rem[R] <= {1'b0, sq_root[R], 1'b0})
        else $error("square-root remainder out of range");
endmodule
